/* design/segment_intersection_test_unit_assert.svh */
// ----------------------------------------------------------------------------
// segment intersection test assertion macros
// concurrent assertion wrappers; empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_TEST_UNIT_ASSERT_SVH
`define SEGMENT_INTERSECTION_TEST_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SIT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define SIT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define SIT_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SIT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* design/sit_pkg.sv */
// ----------------------------------------------------------------------------
// sit_pkg
// shared types of the segment intersection test pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package sit_pkg;

    // number of register stages from input to result
    localparam int NUM_STAGES = 4;

    // flags from the difference stage
    typedef struct packed {
        logic vert;   // both segments have zero x extent
        logic vcol;   // start x values equal
    } t_seg_flags;

    // flags from the multiply stage
    typedef struct packed {
        logic vert;
        logic vcol;
        logic incl;   // endpoint inclusion rule met
    } t_par_flags;

endpackage

`default_nettype wire

/* design/segment_intersection_test_unit.sv */
// throughput: one item per cycle unless the output stalls; the six 17x17 multiplies
// share stage 2; the cross-product subtract and sign compares follow in stages 3 and 4
// an output stall holds full stages with no bubble after them; empty stages still fill
// reset (synchronous, active low) clears the stage valid bits only
// ----------------------------------------------------------------------------
// segment_intersection_test_unit
// strict crossing test of two integer line segments, four-stage pipeline
// ----------------------------------------------------------------------------
`default_nettype none

`include "segment_intersection_test_unit_assert.svh"

module segment_intersection_test_unit import sit_pkg::*; #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input item channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic signed [COORD_WIDTH-1:0] i_first_start_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_first_start_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_first_end_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_first_end_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_second_start_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_second_start_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_second_end_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_second_end_y,
    // result item channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_crossing
);

    localparam int W  = COORD_WIDTH;
    localparam int PW = 2 * W + 2;

    // one valid bit per stage; index 0 is stage 1
    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] n_vld;
    // stage k loads when it is empty or its contents move on
    logic [NUM_STAGES-1:0] stage_en;

    // stage 1 to 2
    logic signed [W:0]   s1_rx, s1_ry, s1_sx, s1_sy, s1_wx, s1_wy;
    logic signed [W-1:0] s1_a1, s1_b1, s1_a2, s1_b2;
    t_seg_flags          s1_flags;

    // stage 2 to 3
    logic signed [PW-1:0] s2_rx_sy, s2_ry_sx, s2_wx_sy, s2_wy_sx, s2_wx_ry, s2_wy_rx;
    t_par_flags           s2_flags;

    // enable chain, last stage first
    always_comb begin
        stage_en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || i_out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !r_vld[k] || stage_en[k+1];
        end
    end

    // valid bits travel alongside the data
    always_comb begin
        n_vld = r_vld;
        if (stage_en[0]) begin
            n_vld[0] = i_in_valid;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (stage_en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready  = stage_en[0];
    assign o_out_valid = r_vld[NUM_STAGES-1];

    // stage 1: r = first end - first start, s = second end - second start,
    // w = second start - first start; coordinate for the parallel rule
    sit_diff #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_diff (
        .i_clk   (i_clk),
        .i_en    (stage_en[0]),
        .i_psx   (i_first_start_x),
        .i_psy   (i_first_start_y),
        .i_pex   (i_first_end_x),
        .i_pey   (i_first_end_y),
        .i_qsx   (i_second_start_x),
        .i_qsy   (i_second_start_y),
        .i_qex   (i_second_end_x),
        .i_qey   (i_second_end_y),
        .o_rx    (s1_rx),
        .o_ry    (s1_ry),
        .o_sx    (s1_sx),
        .o_sy    (s1_sy),
        .o_wx    (s1_wx),
        .o_wy    (s1_wy),
        .o_a1    (s1_a1),
        .o_b1    (s1_b1),
        .o_a2    (s1_a2),
        .o_b2    (s1_b2),
        .o_flags (s1_flags)
    );

    // stage 2: product terms of cross(r,s), cross(w,s) and cross(w,r);
    // the collinearity crosses are the negatives of the last two
    sit_mul #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_mul (
        .i_clk   (i_clk),
        .i_en    (stage_en[1]),
        .i_rx    (s1_rx),
        .i_ry    (s1_ry),
        .i_sx    (s1_sx),
        .i_sy    (s1_sy),
        .i_wx    (s1_wx),
        .i_wy    (s1_wy),
        .i_a1    (s1_a1),
        .i_b1    (s1_b1),
        .i_a2    (s1_a2),
        .i_b2    (s1_b2),
        .i_flags (s1_flags),
        .o_rx_sy (s2_rx_sy),
        .o_ry_sx (s2_ry_sx),
        .o_wx_sy (s2_wx_sy),
        .o_wy_sx (s2_wy_sx),
        .o_wx_ry (s2_wx_ry),
        .o_wy_rx (s2_wy_rx),
        .o_flags (s2_flags)
    );

    // stages 3 and 4: subtract, then strict test or parallel rule
    sit_decide #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_decide (
        .i_clk      (i_clk),
        .i_en3      (stage_en[2]),
        .i_en4      (stage_en[3]),
        .i_rx_sy    (s2_rx_sy),
        .i_ry_sx    (s2_ry_sx),
        .i_wx_sy    (s2_wx_sy),
        .i_wy_sx    (s2_wy_sx),
        .i_wx_ry    (s2_wx_ry),
        .i_wy_rx    (s2_wy_rx),
        .i_flags    (s2_flags),
        .o_crossing (o_crossing)
    );

    // an empty output stage lets the whole pipeline move
    `SIT_ASSERT_IMPLY(a_empty_out_ready, i_clk, i_rst_n, !o_out_valid, o_in_ready)
    // an accepted item lands in stage 1
    `SIT_ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n, i_in_valid && o_in_ready, r_vld[0])
    // an item with a bubble ahead of it always advances
    `SIT_ASSERT_NEXT(a_bubble_moves, i_clk, i_rst_n, r_vld[0] && !r_vld[1], r_vld[1])

endmodule

`default_nettype wire

/* design/sit_diff.sv */
// ----------------------------------------------------------------------------
// sit_diff
// stage 1: edge and offset vectors, parallel-case coordinate select
// ----------------------------------------------------------------------------
`default_nettype none

module sit_diff import sit_pkg::*; #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic signed [COORD_WIDTH-1:0] i_psx,
    input  wire logic signed [COORD_WIDTH-1:0] i_psy,
    input  wire logic signed [COORD_WIDTH-1:0] i_pex,
    input  wire logic signed [COORD_WIDTH-1:0] i_pey,
    input  wire logic signed [COORD_WIDTH-1:0] i_qsx,
    input  wire logic signed [COORD_WIDTH-1:0] i_qsy,
    input  wire logic signed [COORD_WIDTH-1:0] i_qex,
    input  wire logic signed [COORD_WIDTH-1:0] i_qey,
    output logic signed [COORD_WIDTH:0]        o_rx,
    output logic signed [COORD_WIDTH:0]        o_ry,
    output logic signed [COORD_WIDTH:0]        o_sx,
    output logic signed [COORD_WIDTH:0]        o_sy,
    output logic signed [COORD_WIDTH:0]        o_wx,
    output logic signed [COORD_WIDTH:0]        o_wy,
    output logic signed [COORD_WIDTH-1:0]      o_a1,
    output logic signed [COORD_WIDTH-1:0]      o_b1,
    output logic signed [COORD_WIDTH-1:0]      o_a2,
    output logic signed [COORD_WIDTH-1:0]      o_b2,
    output t_seg_flags                         o_flags
);

    localparam int W = COORD_WIDTH;

    logic signed [W:0] n_rx, n_ry, n_sx, n_sy, n_wx, n_wy;
    t_seg_flags        n_flags;

    always_comb begin
        n_rx = $signed({i_pex[W-1], i_pex}) - $signed({i_psx[W-1], i_psx});
        n_ry = $signed({i_pey[W-1], i_pey}) - $signed({i_psy[W-1], i_psy});
        n_sx = $signed({i_qex[W-1], i_qex}) - $signed({i_qsx[W-1], i_qsx});
        n_sy = $signed({i_qey[W-1], i_qey}) - $signed({i_qsy[W-1], i_qsy});
        n_wx = $signed({i_qsx[W-1], i_qsx}) - $signed({i_psx[W-1], i_psx});
        n_wy = $signed({i_qsy[W-1], i_qsy}) - $signed({i_psy[W-1], i_psy});
        n_flags.vert = (n_rx == '0) && (n_sx == '0);
        n_flags.vcol = (i_psx == i_qsx);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rx    <= n_rx;
            o_ry    <= n_ry;
            o_sx    <= n_sx;
            o_sy    <= n_sy;
            o_wx    <= n_wx;
            o_wy    <= n_wy;
            o_flags <= n_flags;
            // vertical pairs compare on y, all others on x
            o_a1    <= n_flags.vert ? i_psy : i_psx;
            o_b1    <= n_flags.vert ? i_pey : i_pex;
            o_a2    <= n_flags.vert ? i_qsy : i_qsx;
            o_b2    <= n_flags.vert ? i_qey : i_qex;
        end
    end

endmodule

`default_nettype wire

/* design/sit_mul.sv */
// ----------------------------------------------------------------------------
// sit_mul
// stage 2: the six cross-product terms and the endpoint inclusion rule
// ----------------------------------------------------------------------------
`default_nettype none

module sit_mul import sit_pkg::*; #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic signed [COORD_WIDTH:0]   i_rx,
    input  wire logic signed [COORD_WIDTH:0]   i_ry,
    input  wire logic signed [COORD_WIDTH:0]   i_sx,
    input  wire logic signed [COORD_WIDTH:0]   i_sy,
    input  wire logic signed [COORD_WIDTH:0]   i_wx,
    input  wire logic signed [COORD_WIDTH:0]   i_wy,
    input  wire logic signed [COORD_WIDTH-1:0] i_a1,
    input  wire logic signed [COORD_WIDTH-1:0] i_b1,
    input  wire logic signed [COORD_WIDTH-1:0] i_a2,
    input  wire logic signed [COORD_WIDTH-1:0] i_b2,
    input  wire t_seg_flags                    i_flags,
    output logic signed [2*COORD_WIDTH+1:0]    o_rx_sy,
    output logic signed [2*COORD_WIDTH+1:0]    o_ry_sx,
    output logic signed [2*COORD_WIDTH+1:0]    o_wx_sy,
    output logic signed [2*COORD_WIDTH+1:0]    o_wy_sx,
    output logic signed [2*COORD_WIDTH+1:0]    o_wx_ry,
    output logic signed [2*COORD_WIDTH+1:0]    o_wy_rx,
    output t_par_flags                         o_flags
);

    localparam int PW = 2 * COORD_WIDTH + 2;

    logic signed [PW-1:0] n_rx_sy, n_ry_sx, n_wx_sy, n_wy_sx, n_wx_ry, n_wy_rx;
    logic                 n_incl;

    always_comb begin
        n_rx_sy = i_rx * i_sy;
        n_ry_sx = i_ry * i_sx;
        n_wx_sy = i_wx * i_sy;
        n_wy_sx = i_wy * i_sx;
        n_wx_ry = i_wx * i_ry;
        n_wy_rx = i_wy * i_rx;
        // order-dependent rule, kept as is
        n_incl  = ((i_a1 >= i_a2) && (i_a1 <= i_b2)) ||
                  ((i_a2 >= i_a1) && (i_a2 <= i_b1)) ||
                  ((i_b1 >= i_a2) && (i_b1 <= i_b2));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rx_sy      <= n_rx_sy;
            o_ry_sx      <= n_ry_sx;
            o_wx_sy      <= n_wx_sy;
            o_wy_sx      <= n_wy_sx;
            o_wx_ry      <= n_wx_ry;
            o_wy_rx      <= n_wy_rx;
            o_flags.vert <= i_flags.vert;
            o_flags.vcol <= i_flags.vcol;
            o_flags.incl <= n_incl;
        end
    end

endmodule

`default_nettype wire

/* design/sit_decide.sv */
// ----------------------------------------------------------------------------
// sit_decide
// stage 3: cross products; stage 4: strict position test and parallel rule
// ----------------------------------------------------------------------------
`default_nettype none

module sit_decide import sit_pkg::*; #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_en3,
    input  wire logic                        i_en4,
    input  wire logic signed [2*COORD_WIDTH+1:0] i_rx_sy,
    input  wire logic signed [2*COORD_WIDTH+1:0] i_ry_sx,
    input  wire logic signed [2*COORD_WIDTH+1:0] i_wx_sy,
    input  wire logic signed [2*COORD_WIDTH+1:0] i_wy_sx,
    input  wire logic signed [2*COORD_WIDTH+1:0] i_wx_ry,
    input  wire logic signed [2*COORD_WIDTH+1:0] i_wy_rx,
    input  wire t_par_flags                  i_flags,
    output logic                             o_crossing
);

    localparam int PW = 2 * COORD_WIDTH + 2;
    localparam int CW = PW + 1;

    logic signed [CW-1:0] r_den, r_nt, r_nu;
    t_par_flags           r_flags;
    logic                 r_hit;
    logic                 n_hit;
    logic                 den_zero, den_neg;
    logic                 t_ok, u_ok, collinear;

    always_ff @(posedge i_clk) begin
        if (i_en3) begin
            r_den   <= $signed({i_rx_sy[PW-1], i_rx_sy}) - $signed({i_ry_sx[PW-1], i_ry_sx});
            r_nt    <= $signed({i_wx_sy[PW-1], i_wx_sy}) - $signed({i_wy_sx[PW-1], i_wy_sx});
            r_nu    <= $signed({i_wx_ry[PW-1], i_wx_ry}) - $signed({i_wy_rx[PW-1], i_wy_rx});
            r_flags <= i_flags;
        end
    end

    always_comb begin
        den_zero = ~|r_den;
        den_neg  = r_den[CW-1];
        // 0 < n/den < 1 without dividing, on either sign of den
        if (den_neg) begin
            t_ok = r_nt[CW-1] && (r_nt > r_den);
            u_ok = r_nu[CW-1] && (r_nu > r_den);
        end else begin
            t_ok = !r_nt[CW-1] && (|r_nt) && (r_nt < r_den);
            u_ok = !r_nu[CW-1] && (|r_nu) && (r_nu < r_den);
        end
        // both w-cross terms zero means the segments share a line
        collinear = r_flags.vert ? r_flags.vcol : ((~|r_nt) && (~|r_nu));
        n_hit     = den_zero ? (collinear && r_flags.incl) : (t_ok && u_ok);
    end

    always_ff @(posedge i_clk) begin
        if (i_en4) begin
            r_hit <= n_hit;
        end
    end

    assign o_crossing = r_hit;

endmodule

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// checks segment_intersection_test_unit item by item against an exact
// integer prediction of the strict crossing test, under random back-pressure
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    import sit_pkg::*;

    localparam int COORD_W      = 16;
    localparam int RESET_CYCLES = 8;
    localparam int LONG_HOLD    = 120;     // receiver hold-off, long enough to fill the pipe
    localparam int CYCLE_LIMIT  = 200000;  // far above the slowest correct run
    localparam int MAX_PRINTS   = 20;

    // one query: first segment p -> e, second segment q -> f
    typedef struct packed {
        logic signed [COORD_W-1:0] p_x;
        logic signed [COORD_W-1:0] p_y;
        logic signed [COORD_W-1:0] e_x;
        logic signed [COORD_W-1:0] e_y;
        logic signed [COORD_W-1:0] q_x;
        logic signed [COORD_W-1:0] q_y;
        logic signed [COORD_W-1:0] f_x;
        logic signed [COORD_W-1:0] f_y;
    } t_seg_pair;

    typedef struct {
        int   seq;
        logic crossing;
    } t_crossing_expect;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic      in_valid  = 1'b0;
    logic      in_taken  = 1'b0;
    logic      out_ready = 1'b0;
    t_seg_pair offered   = '0;

    logic o_in_ready;
    logic o_out_valid;
    logic o_crossing;

    t_seg_pair        pair_queue[$];
    t_crossing_expect crossing_expect[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit recv_hold     = 1'b0;
    int reset_count   = 0;
    int cycle_count   = 0;
    int accept_seq    = 0;
    int fail_count    = 0;

    // clock, period 2
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    segment_intersection_test_unit #(
        .COORD_WIDTH(COORD_W)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_first_start_x (offered.p_x),
        .i_first_start_y (offered.p_y),
        .i_first_end_x   (offered.e_x),
        .i_first_end_y   (offered.e_y),
        .i_second_start_x(offered.q_x),
        .i_second_start_y(offered.q_y),
        .i_second_end_x  (offered.f_x),
        .i_second_end_y  (offered.f_y),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_crossing      (o_crossing)
    );

    // ------------------------------------------------------------------------
    // prediction: exact crossing test in 64-bit integers
    // differences fit 17 bits, products 34 bits, so nothing can overflow
    // ------------------------------------------------------------------------
    function automatic logic predict_crossing(t_seg_pair s);
        longint px, py, ex, ey, qx, qy, fx, fy;
        longint rx, ry, sx, sy, wx, wy;
        longint den, nt, nu;
        longint a1, b1, a2, b2;
        logic   on_line;
        px = longint'(s.p_x);
        py = longint'(s.p_y);
        ex = longint'(s.e_x);
        ey = longint'(s.e_y);
        qx = longint'(s.q_x);
        qy = longint'(s.q_y);
        fx = longint'(s.f_x);
        fy = longint'(s.f_y);
        rx = ex - px;
        ry = ey - py;
        sx = fx - qx;
        sy = fy - qy;
        wx = qx - px;
        wy = qy - py;
        den = rx * sy - ry * sx;
        if (den != 0) begin
            // both positions strictly inside (0,1), compared without dividing
            nt = wx * sy - wy * sx;
            nu = wx * ry - wy * rx;
            if (den < 0) begin
                den = -den;
                nt  = -nt;
                nu  = -nu;
            end
            return (nt > 0) && (nt < den) && (nu > 0) && (nu < den);
        end
        // parallel or degenerate: collinear check, then the endpoint rule
        if (rx == 0 && sx == 0) begin
            on_line = (px == qx);
            a1 = py;
            b1 = ey;
            a2 = qy;
            b2 = fy;
        end else begin
            on_line = (rx * wy - ry * wx == 0) && (sx * wy - sy * wx == 0);
            a1 = px;
            b1 = ex;
            a2 = qx;
            b2 = fx;
        end
        if (!on_line)
            return 1'b0;
        return (a1 >= a2 && a1 <= b2) || (a2 >= a1 && a2 <= b1) ||
               (b1 >= a2 && b1 <= b2);
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_seg_pair make_pair(int px, int py, int ex, int ey,
                                            int qx, int qy, int fx, int fy);
        t_seg_pair s;
        s.p_x = COORD_W'(px);
        s.p_y = COORD_W'(py);
        s.e_x = COORD_W'(ex);
        s.e_y = COORD_W'(ey);
        s.q_x = COORD_W'(qx);
        s.q_y = COORD_W'(qy);
        s.f_x = COORD_W'(fx);
        s.f_y = COORD_W'(fy);
        return s;
    endfunction

    // uniform in [-n, n]
    function automatic int rand_sym(int n);
        return int'($urandom_range(2 * n)) - n;
    endfunction

    // values at and near the ends of the coordinate range
    function automatic int pick_extreme();
        case ($urandom_range(7))
            0: return -32768;
            1: return -32767;
            2: return -1;
            3: return 0;
            4: return 1;
            5: return 32766;
            6: return 32767;
            default: return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    // mostly shaped queries: crossings, touches, collinear and vertical runs,
    // with a share of full-range noise so that every input bit toggles
    function automatic t_seg_pair random_pair();
        int cx, cy, dx, dy, gx, gy, k1, k2, k3, k4, px, py, ex, ey, vx;
        case ($urandom_range(9))
            0, 1: begin
                return make_pair($urandom, $urandom, $urandom, $urandom,
                                 $urandom, $urandom, $urandom, $urandom);
            end
            2: begin
                // tiny grid: lots of parallel, touching and collinear cases
                return make_pair(rand_sym(6), rand_sym(6), rand_sym(6), rand_sym(6),
                                 rand_sym(6), rand_sym(6), rand_sym(6), rand_sym(6));
            end
            3: begin
                // four points on one line, any order along it
                cx = rand_sym(1000);
                cy = rand_sym(1000);
                dx = rand_sym(20);
                dy = rand_sym(20);
                k1 = rand_sym(20);
                k2 = rand_sym(20);
                k3 = rand_sym(20);
                k4 = rand_sym(20);
                return make_pair(cx + k1 * dx, cy + k1 * dy, cx + k2 * dx, cy + k2 * dy,
                                 cx + k3 * dx, cy + k3 * dy, cx + k4 * dx, cy + k4 * dy);
            end
            4: begin
                // vertical or point segments, same x or neighboring x
                vx = rand_sym(30000);
                cx = ($urandom_range(3) == 0) ? vx + 1 : vx;
                return make_pair(vx, rand_sym(10), vx, rand_sym(10),
                                 cx, rand_sym(10), cx, rand_sym(10));
            end
            5: begin
                return make_pair(pick_extreme(), pick_extreme(), pick_extreme(),
                                 pick_extreme(), pick_extreme(), pick_extreme(),
                                 pick_extreme(), pick_extreme());
            end
            6, 7: begin
                // two segments through a common center, usually a true crossing
                cx = rand_sym(10000);
                cy = rand_sym(10000);
                dx = rand_sym(500);
                dy = rand_sym(500);
                gx = rand_sym(500);
                gy = rand_sym(500);
                k1 = $urandom_range(20);
                k2 = $urandom_range(20);
                k3 = $urandom_range(20);
                k4 = $urandom_range(20);
                return make_pair(cx - k1 * dx, cy - k1 * dy, cx + k2 * dx, cy + k2 * dy,
                                 cx - k3 * gx, cy - k3 * gy, cx + k4 * gx, cy + k4 * gy);
            end
            8: begin
                // second segment starts on an endpoint or the midpoint of the first
                px = rand_sym(100);
                py = rand_sym(100);
                ex = px + 2 * rand_sym(50);
                ey = py + 2 * rand_sym(50);
                case ($urandom_range(2))
                    0: begin cx = px; cy = py; end
                    1: begin cx = ex; cy = ey; end
                    default: begin cx = (px + ex) / 2; cy = (py + ey) / 2; end
                endcase
                return make_pair(px, py, ex, ey, cx, cy, rand_sym(100), rand_sym(100));
            end
            default: begin
                // shifted copy of the first segment: parallel, sometimes collinear
                px = rand_sym(2000);
                py = rand_sym(2000);
                dx = rand_sym(40);
                dy = rand_sym(40);
                k1 = rand_sym(3);
                gx = ($urandom_range(1) == 0) ? k1 * dx : rand_sym(5);
                gy = ($urandom_range(1) == 0) ? k1 * dy : rand_sym(5);
                return make_pair(px, py, px + dx, py + dy,
                                 px + gx, py + gy, px + gx + dx, py + gy + dy);
            end
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        fail_count++;
        if (fail_count <= MAX_PRINTS)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    // holds the result side off for a counted stretch
    task automatic hold_receiver(int cycles);
        recv_hold = 1'b1;
        repeat (cycles) @(posedge i_clk);
        recv_hold = 1'b0;
    endtask

    // sender pause: nothing pending, nothing offered, nothing outstanding
    task automatic wait_for_results();
        while (pair_queue.size() != 0 || in_valid || crossing_expect.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // driver: reset sequence and the input item channel, on the falling edge
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (reset_count < RESET_CYCLES) begin
            reset_count++;
            i_rst_n <= 1'b0;
        end else begin
            i_rst_n <= 1'b1;
        end
        // a new item goes out only when the line is free or was just taken
        if (i_rst_n && (!in_valid || in_taken)) begin
            if (pair_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                offered = pair_queue.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result side ready, random unless held off
    always @(negedge i_clk) begin
        out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // monitor: records accepted items and checks results, on the rising edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_crossing_expect want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", CYCLE_LIMIT);
            $display("tb NOT OK");
            $finish;
        end else begin
            in_taken <= i_rst_n && in_valid && o_in_ready;
            if (i_rst_n && in_valid && o_in_ready) begin
                want.seq      = accept_seq;
                want.crossing = predict_crossing(offered);
                crossing_expect.push_back(want);
                accept_seq++;
            end
            if (i_rst_n && o_out_valid && out_ready) begin
                if (crossing_expect.size() == 0) begin
                    report_mismatch("result with no item outstanding");
                end else begin
                    want = crossing_expect.pop_front();
                    if (o_crossing !== want.crossing)
                        report_mismatch($sformatf("item %0d crossing got %b want %b",
                                                  want.seq, o_crossing, want.crossing));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin
        // phase one: sender idles lightly, receiver stalls half the time
        send_idle_pct = 24;
        recv_idle_pct = 50;

        // all points coincide
        pair_queue.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
        pair_queue.push_back(make_pair(-32768, -32768, -32768, -32768,
                                       -32768, -32768, -32768, -32768));
        pair_queue.push_back(make_pair(32767, 32767, 32767, 32767,
                                       32767, 32767, 32767, 32767));
        // plain X crossing, then the same with the first segment reversed
        pair_queue.push_back(make_pair(-10, -10, 10, 10, -10, 10, 10, -10));
        pair_queue.push_back(make_pair(10, 10, -10, -10, -10, 10, 10, -10));
        // T touch and shared endpoint do not count under the strict rule
        pair_queue.push_back(make_pair(0, 0, 10, 0, 5, 0, 5, 10));
        pair_queue.push_back(make_pair(0, 0, 10, 10, 10, 10, 20, 0));
        // non-parallel, lines cross outside both segments
        pair_queue.push_back(make_pair(0, 0, 1, 1, 5, 0, 6, -3));
        // parallel, not collinear
        pair_queue.push_back(make_pair(0, 0, 10, 0, 0, 1, 10, 1));
        // collinear: first start inside second
        pair_queue.push_back(make_pair(5, 0, 20, 0, 0, 0, 10, 0));
        // collinear: second start inside first
        pair_queue.push_back(make_pair(0, 0, 10, 0, 5, 0, 20, 0));
        // collinear: only the first end inside second
        pair_queue.push_back(make_pair(20, 0, 5, 0, 0, 0, 10, 0));
        // collinear overlap that the order-dependent rule misses
        pair_queue.push_back(make_pair(3, 0, 5, 0, 10, 0, 0, 0));
        // collinear but disjoint
        pair_queue.push_back(make_pair(0, 0, 1, 0, 5, 0, 6, 0));
        // vertical pair on the same x, and on neighboring x
        pair_queue.push_back(make_pair(3, 0, 3, 10, 3, 5, 3, 20));
        pair_queue.push_back(make_pair(3, 0, 3, 10, 4, 0, 4, 10));
        // vertical segment and a point on it
        pair_queue.push_back(make_pair(3, 0, 3, 10, 3, 5, 3, 5));
        // point on a sloped segment, and just off it
        pair_queue.push_back(make_pair(0, 0, 10, 10, 5, 5, 5, 5));
        pair_queue.push_back(make_pair(0, 0, 10, 10, 5, 6, 5, 6));
        // full-range diagonals
        pair_queue.push_back(make_pair(-32768, -32768, 32767, 32767,
                                       -32768, 32767, 32767, -32768));
        // full-range horizontals, far apart and overlapping
        pair_queue.push_back(make_pair(-32768, -32768, 32767, -32768,
                                       -32768, 32767, 32767, 32767));
        pair_queue.push_back(make_pair(-32768, 0, 32767, 0, 0, 0, 32767, 0));
        // alternating bit patterns
        pair_queue.push_back(make_pair(21845, -21846, -21846, 21845,
                                       -21846, -21846, 21845, 21845));

        repeat (650) pair_queue.push_back(random_pair());
        wait_for_results();

        // phase two: the other way round
        send_idle_pct = 50;
        recv_idle_pct = 24;
        repeat (650) pair_queue.push_back(random_pair());
        wait_for_results();

        // long receiver hold-off while the sender keeps offering
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fork
            hold_receiver(LONG_HOLD);
        join_none
        repeat (200) pair_queue.push_back(random_pair());
        wait_for_results();

        // phase three: no idling on either side
        repeat (500) pair_queue.push_back(random_pair());
        wait_for_results();

        // let any stray result show up
        repeat (NUM_STAGES + 8) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+design
design/sit_pkg.sv
design/sit_diff.sv
design/sit_mul.sv
design/sit_decide.sv
design/segment_intersection_test_unit.sv
tb/tb.sv
